// File: hdl/nnu_pkg.sv
// ----------------------------------------------------------------------------
// nnu_pkg
// Shared widths, register indexes and types of the nearest-neighbor
// upsampler.
// ----------------------------------------------------------------------------
package nnu_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_STRIDE_DEF = 8;
  localparam int unsigned MAX_HEIGHT     = 1024;
  localparam int unsigned MAX_PLANES     = 4096;

  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned SCALE_W   = 24;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned POS_W     = 13;
  localparam int unsigned PLANE_W   = 12;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned WIDTH_W   = 11;
  localparam int unsigned HEIGHT_W  = 11;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned STRIDE_W  = 4;
  localparam int unsigned REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IN_WIDTH      = 3'd0,
    REG_IN_HEIGHT     = 3'd1,
    REG_PLANE_COUNT   = 3'd2,
    REG_STRIDE        = 3'd3,
    REG_SCALE         = 3'd4,
    REG_BACKWARD_MODE = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [WIDTH_W-1:0]        in_width;
    logic [HEIGHT_W-1:0]       in_height;
    logic [COUNT_W-1:0]        plane_count;
    logic [STRIDE_W-1:0]       stride;
    logic signed [SCALE_W-1:0] scale;
    logic                      backward_mode;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [PLANE_W-1:0] plane;
    logic               first;
    logic               last;
  } tag_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [POS_W-1:0]           base_x;
    logic [POS_W-1:0]           base_y;
    logic [PLANE_W-1:0]         plane;
    logic                       emit;
    logic                       single;
  } emit_item_t;

endpackage

// File: hdl/nnu_if.sv
// ----------------------------------------------------------------------------
// nnu channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface nnu_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [nnu_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface nnu_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [nnu_pkg::SAMPLE_W-1:0] result_value;
  logic [nnu_pkg::POS_W-1:0]           pos_x;
  logic [nnu_pkg::POS_W-1:0]           pos_y;
  logic [nnu_pkg::PLANE_W-1:0]         plane_index;
  logic                                last_of_run;

  modport source (output valid, output result_value, output pos_x, output pos_y,
                  output plane_index, output last_of_run, input ready);
  modport sink (input valid, input result_value, input pos_x, input pos_y,
                input plane_index, input last_of_run, output ready);
endinterface

interface nnu_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [nnu_pkg::REG_IDX_W-1:0]     reg_index;
  logic [nnu_pkg::SCALE_W-1:0]       wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// File: hdl/nearest_neighbour_upsampler_unit.sv
// ----------------------------------------------------------------------------
// nearest_neighbour_upsampler_unit
// Nearest-neighbor upsample of Q16.16 planes, forward replicate or backward
// block-gradient accumulate.
// ----------------------------------------------------------------------------
// Channels: in_req carries one sample per request, out_rsp one result and its
// position per response, cfg_req writes one register (always ready). A write
// to a defined register restarts the column, row and plane counters at zero.
// Pipeline: the first result of a request passes the sample register,
// multiplier, round/saturate with line-buffer read, replicator and output
// register.
// Throughput: forward mode gives stride*stride copies per request, one copy
// per cycle out of the output register while out_rsp is ready. Backward
// mode takes one request per cycle unless a result waits on out_rsp; the
// line buffer does one read and one write per cycle, with a bypass register
// for back-to-back column hits, and only block-ending requests give results.
// Reset: registers take their defaults and counters clear; the line buffer
// needs no clearing since each block's first sample overwrites its entry.
// Stall: when out_rsp is not ready the output register holds; once a result
// waits, the pipe freezes holding up to four requests and in_req drops ready.
// ----------------------------------------------------------------------------
module nearest_neighbour_upsampler_unit #(
  parameter int unsigned MaxWidth  = nnu_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MaxStride = nnu_pkg::MAX_STRIDE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  nnu_in_if.sink      in_req,
  nnu_out_if.source   out_rsp,
  nnu_cfg_if.sink     cfg_req
);

  localparam int unsigned XW = $clog2(MaxWidth);

  nnu_pkg::cfg_t       cfg;
  logic                cfg_clear;
  logic                step;
  logic [XW-1:0]       seq_xi;
  nnu_pkg::tag_t       seq_tag;
  logic                dp_valid, dp_ready;
  nnu_pkg::emit_item_t dp_item;

  nnu_cfg #(
    .MaxWidth  (MaxWidth),
    .MaxStride (MaxStride)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_req (cfg_req),
    .cfg_o   (cfg),
    .clear_o (cfg_clear)
  );

  nnu_seq #(
    .MaxWidth  (MaxWidth),
    .MaxStride (MaxStride)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .clear_i (cfg_clear),
    .step_i  (step),
    .xi_o    (seq_xi),
    .tag_o   (seq_tag)
  );

  nnu_datapath #(
    .MaxWidth (MaxWidth)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_req       (in_req),
    .xi_i         (seq_xi),
    .tag_i        (seq_tag),
    .step_o       (step),
    .item_valid_o (dp_valid),
    .item_o       (dp_item),
    .item_ready_i (dp_ready)
  );

  nnu_emit #(
    .MaxStride (MaxStride)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (dp_valid),
    .item_i       (dp_item),
    .item_ready_o (dp_ready),
    .out_rsp      (out_rsp)
  );

`ifndef NO_ASSERTIONS
  a_dp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_valid && !dp_ready |=> dp_valid && $stable(dp_item))
    else $error("datapath result changed while replicator was busy");

  a_bwd_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_rsp.valid && cfg.backward_mode |-> out_rsp.last_of_run)
    else $error("backward result without last_of_run");

  a_bwd_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_rsp.valid && cfg.backward_mode |-> 32'(out_rsp.pos_x) < MaxWidth)
    else $error("backward result column beyond line buffer");
`endif

endmodule

// File: hdl/nnu_ram.sv
// ----------------------------------------------------------------------------
// nnu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nnu_ram #(
  parameter int unsigned Width = 40,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/nnu_cfg.sv
// ----------------------------------------------------------------------------
// nnu_cfg
// Register file: clamps sizes on write and flags a counter restart.
// ----------------------------------------------------------------------------
module nnu_cfg #(
  parameter int unsigned MaxWidth  = nnu_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MaxStride = nnu_pkg::MAX_STRIDE_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  nnu_cfg_if.sink        cfg_req,
  output nnu_pkg::cfg_t  cfg_o,
  output logic           clear_o
);

  localparam nnu_pkg::cfg_t CfgReset = '{
    in_width:      11'd1,
    in_height:     11'd1,
    plane_count:   13'd1,
    stride:        4'd2,
    scale:         24'sd65536,
    backward_mode: 1'b0
  };

  nnu_pkg::cfg_t cfg_q, cfg_d;
  logic [31:0]   width_c, height_c, count_c, stride_c;

  function automatic logic [31:0] clamp_hi(logic [31:0] v, logic [31:0] hi);
    logic [31:0] r;
    r = (v == 32'd0) ? 32'd1 : v;
    if (r > hi) r = hi;
    return r;
  endfunction

  assign width_c  = clamp_hi(32'(cfg_req.wdata[nnu_pkg::WIDTH_W-1:0]), MaxWidth);
  assign height_c = clamp_hi(32'(cfg_req.wdata[nnu_pkg::HEIGHT_W-1:0]),
                             32'(nnu_pkg::MAX_HEIGHT));
  assign count_c  = clamp_hi(32'(cfg_req.wdata[nnu_pkg::COUNT_W-1:0]),
                             32'(nnu_pkg::MAX_PLANES));
  assign stride_c = clamp_hi(32'(cfg_req.wdata[nnu_pkg::STRIDE_W-1:0]), MaxStride);

  assign cfg_req.ready = 1'b1;

  always_comb begin
    cfg_d   = cfg_q;
    clear_o = 1'b0;
    if (cfg_req.valid) begin
      clear_o = 1'b1;
      case (cfg_req.reg_index)
        nnu_pkg::REG_IN_WIDTH:      cfg_d.in_width = width_c[nnu_pkg::WIDTH_W-1:0];
        nnu_pkg::REG_IN_HEIGHT:     cfg_d.in_height = height_c[nnu_pkg::HEIGHT_W-1:0];
        nnu_pkg::REG_PLANE_COUNT:   cfg_d.plane_count = count_c[nnu_pkg::COUNT_W-1:0];
        nnu_pkg::REG_STRIDE:        cfg_d.stride = stride_c[nnu_pkg::STRIDE_W-1:0];
        nnu_pkg::REG_SCALE:         cfg_d.scale = cfg_req.wdata;
        nnu_pkg::REG_BACKWARD_MODE: cfg_d.backward_mode = cfg_req.wdata[0];
        default:                    clear_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/nnu_seq.sv
// ----------------------------------------------------------------------------
// nnu_seq
// Position counters: tag each accepted request with column, row, plane and
// block-corner flags.
// ----------------------------------------------------------------------------
module nnu_seq #(
  parameter int unsigned MaxWidth  = nnu_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MaxStride = nnu_pkg::MAX_STRIDE_DEF,
  localparam int unsigned XW = $clog2(MaxWidth)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  nnu_pkg::cfg_t  cfg_i,
  input  logic           clear_i,
  input  logic           step_i,
  output logic [XW-1:0]  xi_o,
  output nnu_pkg::tag_t  tag_o
);

  localparam int unsigned SW = $clog2(MaxStride);
  localparam int unsigned RW = nnu_pkg::ROW_W;
  localparam int unsigned PW = nnu_pkg::PLANE_W;

  logic [XW-1:0] xi_q, xi_d;
  logic [RW-1:0] yi_q, yi_d;
  logic [PW-1:0] pl_q, pl_d;
  logic [SW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic          sx_end, sy_end, sx_wrap, sy_wrap, x_end, y_end, p_end;

  assign sx_end  = 32'(sx_q) == 32'(cfg_i.stride) - 32'd1;
  assign sy_end  = 32'(sy_q) == 32'(cfg_i.stride) - 32'd1;
  assign sx_wrap = !cfg_i.backward_mode || sx_end;
  assign sy_wrap = !cfg_i.backward_mode || sy_end;
  assign x_end   = 32'(xi_q) == 32'(cfg_i.in_width) - 32'd1;
  assign y_end   = 32'(yi_q) == 32'(cfg_i.in_height) - 32'd1;
  assign p_end   = 32'(pl_q) == 32'(cfg_i.plane_count) - 32'd1;

  always_comb begin
    xi_d = xi_q;
    yi_d = yi_q;
    pl_d = pl_q;
    sx_d = sx_q;
    sy_d = sy_q;
    if (clear_i) begin
      xi_d = '0;
      yi_d = '0;
      pl_d = '0;
      sx_d = '0;
      sy_d = '0;
    end else if (step_i) begin
      if (!sx_wrap) begin
        sx_d = sx_q + SW'(1);
      end else begin
        sx_d = '0;
        if (!x_end) begin
          xi_d = xi_q + XW'(1);
        end else begin
          xi_d = '0;
          if (!sy_wrap) begin
            sy_d = sy_q + SW'(1);
          end else begin
            sy_d = '0;
            if (!y_end) begin
              yi_d = yi_q + RW'(1);
            end else begin
              yi_d = '0;
              pl_d = p_end ? '0 : pl_q + PW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xi_q <= '0;
      yi_q <= '0;
      pl_q <= '0;
      sx_q <= '0;
      sy_q <= '0;
    end else begin
      xi_q <= xi_d;
      yi_q <= yi_d;
      pl_q <= pl_d;
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
  end

  assign xi_o        = xi_q;
  assign tag_o.row   = yi_q;
  assign tag_o.plane = pl_q;
  assign tag_o.first = (sx_q == '0) && (sy_q == '0);
  assign tag_o.last  = sx_end && sy_end;

endmodule

// File: hdl/nnu_datapath.sv
// ----------------------------------------------------------------------------
// nnu_datapath
// Scale, round and saturate each sample; in gradient mode accumulate block
// sums in the line buffer by read-modify-write with a one-entry bypass.
// ----------------------------------------------------------------------------
module nnu_datapath #(
  parameter int unsigned MaxWidth = nnu_pkg::MAX_WIDTH_DEF,
  localparam int unsigned XW = $clog2(MaxWidth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nnu_pkg::cfg_t       cfg_i,
  nnu_in_if.sink              in_req,
  input  logic [XW-1:0]       xi_i,
  input  nnu_pkg::tag_t       tag_i,
  output logic                step_o,
  output logic                item_valid_o,
  output nnu_pkg::emit_item_t item_o,
  input  logic                item_ready_i
);

  localparam int unsigned SmpW  = nnu_pkg::SAMPLE_W;
  localparam int unsigned SumW  = nnu_pkg::SUM_W;
  localparam int unsigned ProdW = nnu_pkg::SAMPLE_W + nnu_pkg::SCALE_W;
  localparam int unsigned PosW  = nnu_pkg::POS_W;

  logic                    v1_q, v2_q, v3_q;
  logic signed [SmpW-1:0]  smp1_q;
  logic signed [ProdW-1:0] prod2_q, prod2_d, rnd;
  logic signed [SmpW-1:0]  term3_q, term3_d;
  logic signed [SumW-1:0]  shr, term_ext, old_sum, sum;
  logic [XW-1:0]           xi1_q, xi2_q, xi3_q;
  nnu_pkg::tag_t           tag1_q, tag2_q, tag3_q;
  logic [SumW-1:0]         ram_rdata;
  logic                    ram_we;
  logic                    byp_v_q;
  logic [XW-1:0]           byp_addr_q;
  logic signed [SumW-1:0]  byp_data_q;
  logic [XW+nnu_pkg::STRIDE_W-1:0]            xs;
  logic [nnu_pkg::ROW_W+nnu_pkg::STRIDE_W-1:0] ys;

  function automatic logic signed [SmpW-1:0] sat32(logic signed [SumW-1:0] v);
    logic signed [SmpW-1:0] r;
    if (v[SumW-1:SmpW-1] == '0 || v[SumW-1:SmpW-1] == '1) begin
      r = v[SmpW-1:0];
    end else begin
      r = v[SumW-1] ? {1'b1, {(SmpW-1){1'b0}}} : {1'b0, {(SmpW-1){1'b1}}};
    end
    return r;
  endfunction

  assign in_req.ready = item_ready_i;
  assign step_o       = in_req.valid && item_ready_i;

  assign prod2_d = ProdW'(smp1_q) * ProdW'($signed(cfg_i.scale));
  assign rnd     = prod2_q + $signed(ProdW'(32768));
  assign shr     = rnd[ProdW-1:16];
  assign term3_d = sat32(shr);

  assign term_ext = SumW'(term3_q);
  assign old_sum  = (byp_v_q && byp_addr_q == xi3_q) ? byp_data_q : ram_rdata;
  assign sum      = tag3_q.first ? term_ext : old_sum + term_ext;
  assign ram_we   = item_ready_i && v3_q && cfg_i.backward_mode;

  nnu_ram #(
    .Width (SumW),
    .Depth (MaxWidth)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (xi3_q),
    .wdata_i (sum),
    .re_i    (item_ready_i),
    .raddr_i (xi2_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      byp_v_q <= 1'b0;
    end else begin
      if (item_ready_i) begin
        v1_q <= in_req.valid;
        v2_q <= v1_q;
        v3_q <= v2_q;
      end
      if (ram_we) begin
        byp_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ready_i) begin
      smp1_q  <= in_req.sample_value;
      xi1_q   <= xi_i;
      tag1_q  <= tag_i;
      prod2_q <= prod2_d;
      xi2_q   <= xi1_q;
      tag2_q  <= tag1_q;
      term3_q <= term3_d;
      xi3_q   <= xi2_q;
      tag3_q  <= tag2_q;
    end
    if (ram_we) begin
      byp_addr_q <= xi3_q;
      byp_data_q <= sum;
    end
  end

  assign xs = xi3_q * cfg_i.stride;
  assign ys = tag3_q.row * cfg_i.stride;

  assign item_valid_o  = v3_q;
  assign item_o.value  = cfg_i.backward_mode ? sat32(sum) : term3_q;
  assign item_o.base_x = cfg_i.backward_mode ? PosW'(xi3_q) : PosW'(xs);
  assign item_o.base_y = cfg_i.backward_mode ? PosW'(tag3_q.row) : PosW'(ys);
  assign item_o.plane  = tag3_q.plane;
  assign item_o.emit   = !cfg_i.backward_mode || tag3_q.last;
  assign item_o.single = cfg_i.backward_mode;

endmodule

// File: hdl/nnu_emit.sv
// ----------------------------------------------------------------------------
// nnu_emit
// Replicate each forward result over its block; drive the output register.
// ----------------------------------------------------------------------------
module nnu_emit #(
  parameter int unsigned MaxStride = nnu_pkg::MAX_STRIDE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nnu_pkg::cfg_t       cfg_i,
  input  logic                item_valid_i,
  input  nnu_pkg::emit_item_t item_i,
  output logic                item_ready_o,
  nnu_out_if.source           out_rsp
);

  localparam int unsigned SW   = $clog2(MaxStride);
  localparam int unsigned PosW = nnu_pkg::POS_W;

  logic                          p4_v_q;
  nnu_pkg::emit_item_t           item_q;
  logic [SW-1:0]                 dx_q, dx_d, dy_q, dy_d;
  logic                          out_v_q, out_v_d;
  logic signed [nnu_pkg::SAMPLE_W-1:0] res_q;
  logic [PosW-1:0]               pos_x_q, pos_y_q;
  logic [nnu_pkg::PLANE_W-1:0]   plane_q;
  logic                          last_q;
  logic                          dx_end, dy_end, copy_last, out_free, send, take;

  assign dx_end    = 32'(dx_q) == 32'(cfg_i.stride) - 32'd1;
  assign dy_end    = 32'(dy_q) == 32'(cfg_i.stride) - 32'd1;
  assign copy_last = item_q.single || (dx_end && dy_end);
  assign out_free  = !out_v_q || out_rsp.ready;
  assign send      = p4_v_q && item_q.emit && out_free;
  assign take      = p4_v_q && (!item_q.emit || (out_free && copy_last));

  assign item_ready_o = !p4_v_q || take;
  assign out_v_d      = send || (out_v_q && !out_rsp.ready);

  always_comb begin
    dx_d = dx_q;
    dy_d = dy_q;
    if (take) begin
      dx_d = '0;
      dy_d = '0;
    end else if (send) begin
      if (dx_end) begin
        dx_d = '0;
        dy_d = dy_q + SW'(1);
      end else begin
        dx_d = dx_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      dx_q    <= '0;
      dy_q    <= '0;
    end else begin
      if (item_ready_o) begin
        p4_v_q <= item_valid_i;
      end
      out_v_q <= out_v_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_ready_o) begin
      item_q <= item_i;
    end
    if (send) begin
      res_q   <= item_q.value;
      pos_x_q <= item_q.base_x + PosW'(dx_q);
      pos_y_q <= item_q.base_y + PosW'(dy_q);
      plane_q <= item_q.plane;
      last_q  <= copy_last;
    end
  end

  assign out_rsp.valid        = out_v_q;
  assign out_rsp.result_value = res_q;
  assign out_rsp.pos_x        = pos_x_q;
  assign out_rsp.pos_y        = pos_y_q;
  assign out_rsp.plane_index  = plane_q;
  assign out_rsp.last_of_run  = last_q;

endmodule

// File: tb/nnu_upsample_checker.sv
// ----------------------------------------------------------------------------
// nnu_upsample_checker
// Watches the register, sample and result channels of the nearest-neighbor
// upsampler. It keeps its own copy of the registers, the raster counters and
// the block-sum line buffer. From these it works out the results of every
// accepted sample and compares each accepted result, field by field, with
// the oldest one still due.
// ----------------------------------------------------------------------------
module nnu_upsample_checker (
  input  logic clk_i,
  input  logic rst_ni,
  nnu_in_if    in_mon,
  nnu_out_if   out_mon,
  nnu_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import nnu_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [POS_W-1:0]           pos_x;
    logic [POS_W-1:0]           pos_y;
    logic [PLANE_W-1:0]         plane;
    logic                       last;
  } result_t;

  cfg_t                    cfg_q;
  logic [POS_W-1:0]        col_q;
  logic [POS_W-1:0]        row_q;
  logic [PLANE_W-1:0]      plane_q;
  logic signed [SUM_W-1:0] block_sum [MAX_WIDTH_DEF];
  result_t                 due_q[$];
  int                      fails;

  function automatic int clamp_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_word(logic signed [63:0] v);
    if (v > 64'sd2147483647) return {1'b0, {31{1'b1}}};
    if (v < -64'sd2147483648) return {1'b1, {31{1'b0}}};
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] scaled_term(
    logic signed [SAMPLE_W-1:0] s, logic signed [SCALE_W-1:0] k);
    logic signed [63:0] prod;
    prod = 64'(s) * 64'(k);
    prod = (prod + 64'sd32768) >>> 16;
    return sat_word(prod);
  endfunction

  function automatic void write_register(logic [REG_IDX_W-1:0] idx,
                                         logic [SCALE_W-1:0] data);
    case (idx)
      REG_IN_WIDTH:      cfg_q.in_width = data[WIDTH_W-1:0];
      REG_IN_HEIGHT:     cfg_q.in_height = data[HEIGHT_W-1:0];
      REG_PLANE_COUNT:   cfg_q.plane_count = data[COUNT_W-1:0];
      REG_STRIDE:        cfg_q.stride = data[STRIDE_W-1:0];
      REG_SCALE:         cfg_q.scale = data;
      REG_BACKWARD_MODE: cfg_q.backward_mode = data[0];
      default:           return;
    endcase
    col_q = '0;
    row_q = '0;
    plane_q = '0;
  endfunction

  function automatic void predict_sample(logic signed [SAMPLE_W-1:0] s);
    int w, h, np, st, c, r, p, lim_x, lim_y, xi, sx, sy, dx, dy;
    logic signed [SAMPLE_W-1:0] term;
    w = clamp_to(int'(cfg_q.in_width), 1, MAX_WIDTH_DEF);
    h = clamp_to(int'(cfg_q.in_height), 1, MAX_HEIGHT);
    np = clamp_to(int'(cfg_q.plane_count), 1, MAX_PLANES);
    st = clamp_to(int'(cfg_q.stride), 1, MAX_STRIDE_DEF);
    term = scaled_term(s, cfg_q.scale);
    c = col_q;
    r = row_q;
    p = plane_q;
    if (!cfg_q.backward_mode) begin
      lim_x = w;
      lim_y = h;
    end else begin
      lim_x = w * st;
      lim_y = h * st;
    end
    if (c >= lim_x) c = 0;
    if (r >= lim_y) r = 0;
    if (p >= np) p = 0;
    if (!cfg_q.backward_mode) begin
      for (dy = 0; dy < st; dy++) begin
        for (dx = 0; dx < st; dx++) begin
          due_q.push_back('{term, POS_W'(c * st + dx), POS_W'(r * st + dy),
                            PLANE_W'(p), (dy == st - 1) && (dx == st - 1)});
        end
      end
    end else begin
      xi = c / st;
      sx = c % st;
      sy = r % st;
      if (xi >= MAX_WIDTH_DEF) xi = MAX_WIDTH_DEF - 1;
      if (sx == 0 && sy == 0) begin
        block_sum[xi] = SUM_W'(term);
      end else begin
        block_sum[xi] = block_sum[xi] + SUM_W'(term);
      end
      if (sx == st - 1 && sy == st - 1) begin
        due_q.push_back('{sat_word(64'(block_sum[xi])), POS_W'(xi), POS_W'(r / st),
                          PLANE_W'(p), 1'b1});
      end
    end
    c++;
    if (c >= lim_x) begin
      c = 0;
      r++;
      if (r >= lim_y) begin
        r = 0;
        p++;
        if (p >= np) p = 0;
      end
    end
    col_q = POS_W'(c);
    row_q = POS_W'(r);
    plane_q = PLANE_W'(p);
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
      fails++;
    end
  endfunction

  function automatic void check_result();
    result_t want;
    if (due_q.size() == 0) begin
      $error("result with none due: result_value 'h%0h pos_x %0d pos_y %0d plane %0d",
             out_mon.result_value, out_mon.pos_x, out_mon.pos_y, out_mon.plane_index);
      fails++;
      return;
    end
    want = due_q.pop_front();
    compare_field("result_value", want.value, out_mon.result_value);
    compare_field("pos_x", 32'(want.pos_x), 32'(out_mon.pos_x));
    compare_field("pos_y", 32'(want.pos_y), 32'(out_mon.pos_y));
    compare_field("plane_index", 32'(want.plane), 32'(out_mon.plane_index));
    compare_field("last_of_run", 32'(want.last), 32'(out_mon.last_of_run));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_width = 1;
      cfg_q.in_height = 1;
      cfg_q.plane_count = 1;
      cfg_q.stride = 2;
      cfg_q.scale = 24'sh010000;
      cfg_q.backward_mode = 1'b0;
      col_q = '0;
      row_q = '0;
      plane_q = '0;
      due_q.delete();
      fails = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) write_register(cfg_mon.reg_index, cfg_mon.wdata);
      if (in_mon.valid && in_mon.ready) predict_sample(in_mon.sample_value);
      if (out_mon.valid && out_mon.ready) check_result();
    end
    fail_count_o <= fails;
    pending_o <= due_q.size();
  end

endmodule

// File: tb/nearest_neighbour_upsampler_unit_test.sv
// ----------------------------------------------------------------------------
// nearest_neighbour_upsampler_unit_test
// Drives the upsampler through a short directed part (reset defaults, field
// extremes, out-of-range sizes, saturating block sums) and then random
// phases of forward and backward streams under random register settings,
// with bursts of idle and stall on both channels. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module nearest_neighbour_upsampler_unit_test;
  import nnu_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int TargetItems = 480;
  localparam int CalmTail    = 80;
  localparam int SettleCycles = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic gaps_on;
  int   stall_left;
  int   sent;
  int   fail_count;
  int   pending;

  nnu_in_if  in_req ();
  nnu_out_if out_rsp ();
  nnu_cfg_if cfg_req ();

  nearest_neighbour_upsampler_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_req (cfg_req)
  );

  nnu_upsample_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_req),
    .out_mon      (out_rsp),
    .cfg_mon      (cfg_req),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_rsp.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_rsp.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      out_rsp.ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_rsp.ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] data);
    cfg_req.valid <= 1'b1;
    cfg_req.reg_index <= idx;
    cfg_req.wdata <= data;
    @(posedge clk_i);
    while (!cfg_req.ready) @(posedge clk_i);
  endtask

  task automatic configure(input int w, input int h, input int p, input int s,
                           input logic [SCALE_W-1:0] k, input bit bw);
    write_reg(REG_IN_WIDTH, {13'($urandom), 11'(w)});
    write_reg(REG_IN_HEIGHT, {13'($urandom), 11'(h)});
    write_reg(REG_PLANE_COUNT, {11'($urandom), 13'(p)});
    write_reg(REG_STRIDE, {20'($urandom), 4'(s)});
    write_reg(REG_SCALE, k);
    write_reg(REG_BACKWARD_MODE, {23'($urandom), bw});
    cfg_req.valid <= 1'b0;
  endtask

  task automatic poke_spare();
    write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 24'($urandom));
    cfg_req.valid <= 1'b0;
  endtask

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] v);
    if (sent >= TargetItems - CalmTail) gaps_on <= 1'b0;
    if (gaps_on && (sent < TargetItems - CalmTail) && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_req.valid <= 1'b1;
    in_req.sample_value <= v;
    @(posedge clk_i);
    while (!in_req.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic wait_idle();
    in_req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3, 4: return 32'($urandom);
      default: return 32'(int'($urandom_range(0, 2 ** 21)) - 2 ** 20);
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return 24'h800000;
      1:       return 24'h7fffff;
      2:       return 24'h000000;
      3, 4:    return 24'h010000;
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    int w, h, p, s, eff_s, eff_w, n, kind;
    bit bw;
    in_req.valid <= 1'b0;
    in_req.sample_value <= '0;
    cfg_req.valid <= 1'b0;
    cfg_req.reg_index <= '0;
    cfg_req.wdata <= '0;
    gaps_on <= 1'b0;
    sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults
    push_sample(32'sh7fffffff);
    push_sample(32'sh80000000);
    push_sample(-32'sd1);
    wait_idle();
    poke_spare();

    // zero sizes act as one, most negative scale
    configure(0, 0, 0, 0, 24'h800000, 1'b0);
    push_sample(32'sh7fffffff);
    push_sample(32'sh80000000);
    push_sample(32'sd1);
    push_sample(32'sh00010000);
    wait_idle();

    // oversize settings clamp, widest stride
    configure(2047, 2047, 8191, 15, 24'h7fffff, 1'b0);
    push_sample(32'sh7fffffff);
    push_sample(-32'sd3);
    wait_idle();

    // backward, block sums saturating both ways
    configure(2, 1, 2, 2, 24'h010000, 1'b1);
    for (int i = 0; i < 16; i++) begin
      if (i < 8) push_sample((i % 4) < 2 ? 32'sh7fffffff : 32'sh80000000);
      else push_sample(pick_sample());
    end
    wait_idle();

    while (sent < TargetItems) begin
      gaps_on <= (sent < TargetItems - CalmTail) && ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 11);
      if (kind == 0) begin
        poke_spare();
      end else begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 4);
        p = $urandom_range(1, 3);
        s = $urandom_range(1, 4);
        bw = $urandom_range(0, 1);
        if (kind == 1) s = $urandom_range(5, 8);
        if (kind == 2) begin
          w = $urandom_range(100, 2047);
          s = $urandom_range(1, 2);
        end
        if (kind == 3) begin
          s = $urandom_range(0, 1) ? 15 : 0;
          w = $urandom_range(0, 1) ? 0 : w;
          h = $urandom_range(0, 1) ? 0 : h;
          p = $urandom_range(0, 1) ? 0 : p;
        end
        configure(w, h, p, s, pick_scale(), bw);
      end
      eff_s = (s < 1) ? 1 : ((s > 8) ? 8 : s);
      eff_w = (w < 1) ? 1 : ((w > 1024) ? 1024 : w);
      if (!bw) begin
        n = $urandom_range(6, 30);
      end else begin
        n = eff_w * eff_s * eff_s * $urandom_range(1, (h < 1) ? 1 : h);
        if (n > 200) n = 200;
        n += $urandom_range(0, 3);
      end
      if (n > TargetItems - sent) n = TargetItems - sent;
      for (int i = 0; i < n; i++) push_sample(pick_sample());
      wait_idle();
    end

    gaps_on <= 1'b0;
    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
